// ===== rtl/core/tvst_pkg.sv =====
// Package: types and status codes for the two-version snapshot table.
`timescale 1ns / 1ps
package tvst_pkg;
    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_STATE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_MARKED    = 3'd5,
        ST_FULL      = 3'd6,
        ST_STATE     = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EXEC,
        S_DONE
    } t_state;

    localparam int GEN_BITS = 32;
    localparam int TO_BITS  = 64;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        key;
        logic [31:0]        write_value;
        logic signed [63:0] timeout;
        logic               for_snapshot;
        logic               target_state;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic        snapshot_active;
        logic [31:0] current_gen;
    } t_rsp;
endpackage

// ===== rtl/core/two_version_snapshot_table.sv =====
// Top level: two-version snapshot key/value table with a sequential key scan.
`timescale 1ns / 1ps
// One request at a time. A put, remove or get walks the entry memory one entry per
// cycle through a single key comparator, then reads the slots and executes; a set-state
// request goes straight to execute. The key scan over the entry memory sets the rate.
// Entry contents come up undefined after reset; only per-entry used bits are cleared.
module two_version_snapshot_table #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tvst_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output tvst_pkg::t_rsp   o_rsp
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int GB = tvst_pkg::GEN_BITS;
    localparam int TB = tvst_pkg::TO_BITS;
    localparam int SW = 1 + VALUE_BITS + GB + TB;

    typedef struct packed {
        logic                  present;
        logic [VALUE_BITS-1:0] value;
        logic [GB-1:0]         gen;
        logic [TB-1:0]         timeout;
    } t_slot;

    logic [KEY_BITS-1:0] m_key [ENTRIES];
    logic [SW-1:0]       m_a   [ENTRIES];
    logic [SW-1:0]       m_b   [ENTRIES];
    logic [ENTRIES-1:0]  r_used;

    tvst_pkg::t_state r_state, n_state;
    tvst_pkg::t_req   r_req;
    tvst_pkg::t_rsp   r_rsp;
    logic             r_snap;
    logic [GB-1:0]    r_gen;
    logic [CW-1:0]    r_cnt;
    logic             r_hit, r_free_ok;
    logic [IW-1:0]    r_hit_idx, r_free_idx;
    logic [KEY_BITS-1:0] r_rkey;
    logic             r_rkey_ok;
    t_slot            r_sa, r_sb;

    logic [IW-1:0]       w_idx;
    logic [KEY_BITS-1:0] w_key;
    logic [GB-1:0]       w_g, w_lim;
    logic                w_pick_a, w_use_a, w_newer;
    logic                w_wr_a, w_wr_b, w_wr_key;
    t_slot               w_wslot, w_bslot;
    logic                w_in_acc, w_out_acc;

    assign w_idx     = r_cnt[IW-1:0];
    assign w_key     = KEY_BITS'(r_req.key);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign o_ready   = (r_state == tvst_pkg::S_IDLE);
    assign o_valid   = (r_state == tvst_pkg::S_DONE);
    assign o_rsp     = r_rsp;

    assign w_g      = r_snap ? r_gen + 1'b1 : r_gen;
    assign w_lim    = (!r_req.for_snapshot && r_snap) ? r_gen + 1'b1 : r_gen;
    assign w_pick_a = (r_sa.gen == w_g) || ((r_sa.gen < r_sb.gen) && (r_sb.gen != w_g));
    assign w_newer  = (r_sa.gen > r_sb.gen) ? r_sa.present : r_sb.present;
    assign w_use_a  = ((r_sa.gen > r_sb.gen) || (r_sb.gen > w_lim)) && (r_sa.gen <= w_lim);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tvst_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_req.op == tvst_pkg::OP_STATE) ? tvst_pkg::S_EXEC
                                                               : tvst_pkg::S_SCAN;
                end
            end
            tvst_pkg::S_SCAN: begin
                if (r_cnt == CW'(ENTRIES)) begin
                    n_state = tvst_pkg::S_READ;
                end
            end
            tvst_pkg::S_READ: n_state = tvst_pkg::S_EXEC;
            tvst_pkg::S_EXEC: n_state = tvst_pkg::S_DONE;
            tvst_pkg::S_DONE: begin
                if (i_ready) begin
                    n_state = tvst_pkg::S_IDLE;
                end
            end
            default: n_state = tvst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_wr_a   = 1'b0;
        w_wr_b   = 1'b0;
        w_wr_key = 1'b0;
        w_wslot  = '0;
        w_bslot  = '0;
        if (r_state == tvst_pkg::S_EXEC) begin
            unique case (tvst_pkg::t_op'(r_req.op))
                tvst_pkg::OP_PUT: begin
                    w_wslot.present = 1'b1;
                    w_wslot.value   = VALUE_BITS'(r_req.write_value);
                    w_wslot.gen     = w_g;
                    w_wslot.timeout = r_req.timeout;
                    if (r_hit) begin
                        w_wr_a = w_pick_a;
                        w_wr_b = !w_pick_a;
                    end else if (r_free_ok) begin
                        w_wr_a   = 1'b1;
                        w_wr_b   = 1'b1;
                        w_wr_key = 1'b1;
                    end
                end
                tvst_pkg::OP_REMOVE: begin
                    w_wslot.gen     = w_g;
                    w_wslot.timeout = '1;
                    if (r_hit && r_snap) begin
                        w_wr_a = w_pick_a;
                        w_wr_b = !w_pick_a;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tvst_pkg::S_SCAN && r_cnt < CW'(ENTRIES)) begin
            r_rkey <= m_key[w_idx];
        end
        if (r_state == tvst_pkg::S_READ) begin
            r_sa <= t_slot'(m_a[r_hit_idx]);
            r_sb <= t_slot'(m_b[r_hit_idx]);
        end
        if (w_wr_key) begin
            m_key[r_free_idx] <= w_key;
        end
        if (w_wr_a) begin
            m_a[r_hit ? r_hit_idx : r_free_idx] <= SW'(w_wslot);
        end
        if (w_wr_b) begin
            m_b[r_hit ? r_hit_idx : r_free_idx] <= r_hit ? SW'(w_wslot) : SW'(w_bslot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tvst_pkg::S_IDLE;
            r_used    <= '0;
            r_snap    <= 1'b0;
            r_gen     <= GB'(1);
            r_cnt     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_rkey_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_req     <= i_req;
                r_cnt     <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_rkey_ok <= 1'b0;
            end
            if (r_state == tvst_pkg::S_SCAN) begin
                // compare the key read last cycle, issue the next read
                if (r_rkey_ok && !r_hit && r_used[r_hit_idx] && r_rkey == w_key) begin
                    r_hit <= 1'b1;
                end
                if (!r_hit && !(r_rkey_ok && r_used[r_hit_idx] && r_rkey == w_key)) begin
                    r_hit_idx <= w_idx;
                end
                if (r_cnt < CW'(ENTRIES)) begin
                    if (!r_free_ok && !r_used[w_idx]) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= w_idx;
                    end
                    r_rkey_ok <= 1'b1;
                    r_cnt     <= r_cnt + 1'b1;
                end
            end
            if (r_state == tvst_pkg::S_EXEC) begin
                r_rsp.read_value <= '0;
                unique case (tvst_pkg::t_op'(r_req.op))
                    tvst_pkg::OP_PUT: begin
                        if (r_hit) begin
                            r_rsp.status <= tvst_pkg::ST_UPDATED;
                        end else if (r_free_ok) begin
                            r_used[r_free_idx] <= 1'b1;
                            r_rsp.status <= tvst_pkg::ST_ADDED;
                        end else begin
                            r_rsp.status <= tvst_pkg::ST_FULL;
                        end
                    end
                    tvst_pkg::OP_REMOVE: begin
                        if (!r_hit) begin
                            r_rsp.status <= tvst_pkg::ST_NOT_FOUND;
                        end else if (!r_snap) begin
                            r_used[r_hit_idx] <= 1'b0;
                            r_rsp.status <= tvst_pkg::ST_REMOVED;
                        end else begin
                            r_rsp.status <= tvst_pkg::ST_MARKED;
                        end
                    end
                    tvst_pkg::OP_GET: begin
                        r_rsp.status <= tvst_pkg::ST_NOT_FOUND;
                        if (r_hit) begin
                            if (!w_newer) begin
                                if (!r_snap) begin
                                    r_used[r_hit_idx] <= 1'b0;
                                end
                            end else if (w_use_a ? r_sa.present : r_sb.present) begin
                                r_rsp.status     <= tvst_pkg::ST_FOUND;
                                r_rsp.read_value <= 32'(w_use_a ? r_sa.value : r_sb.value);
                            end
                        end
                    end
                    tvst_pkg::OP_STATE: begin
                        r_rsp.status <= tvst_pkg::ST_STATE;
                    end
                    default: ;
                endcase
                if (r_req.op == tvst_pkg::OP_STATE) begin
                    if (r_snap && !r_req.target_state) begin
                        r_snap <= 1'b0;
                        r_gen  <= r_gen + 1'b1;
                        r_rsp.snapshot_active <= 1'b0;
                        r_rsp.current_gen     <= r_gen + 1'b1;
                    end else begin
                        r_snap <= r_req.target_state;
                        r_rsp.snapshot_active <= r_req.target_state;
                        r_rsp.current_gen     <= r_gen;
                    end
                end else begin
                    r_rsp.snapshot_active <= r_snap;
                    r_rsp.current_gen     <= r_gen;
                end
            end
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while result pending");
    a_gen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != $past(r_gen) |-> r_gen == $past(r_gen) + 1'b1 && $fell(r_snap))
        else $error("generation changed without leaving snapshot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result dropped");
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tvst_pkg::S_SCAN |-> r_cnt <= CW'(ENTRIES))
        else $error("scan overrun");
endmodule
